// ===== rtl/core/bmso_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, stage types and the quarter-wave sine table of the oscillator.
package bmso_pkg;

	localparam int PHASE_BITS     = 32;
	localparam int SINE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS    = 16;
	localparam int INC_BITS       = 32;
	localparam int BYTE_BITS      = 8;

	localparam logic [INC_BITS-1:0] INC_RESET = 32'd1118481067;

	localparam int QUARTER_SHIFT = SINE_ADDR_BITS - 2;
	localparam int QUARTER_LEN   = 1 << QUARTER_SHIFT;
	localparam int IDX_BITS      = QUARTER_SHIFT + 1;
	localparam int MAG_BITS      = SAMPLE_BITS - 1;
	localparam int PROD_BITS     = MAG_BITS + BYTE_BITS;

	// Division by 255 as a multiplication by a rounded-up reciprocal; the error term
	// (at most 254) times the largest dividend stays below 2^DIV_SHIFT, so it is exact.
	localparam int DIV_SHIFT  = PROD_BITS + 8;
	localparam int RECIP_BITS = DIV_SHIFT - 7;
	localparam int WIDE_BITS  = PROD_BITS + RECIP_BITS;
	localparam logic [RECIP_BITS-1:0] RECIP =
		RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'd254) / 64'd255);
	localparam logic [PROD_BITS-1:0] ROUND_BIAS = PROD_BITS'(127);

	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
	localparam logic [63:0] PEAK        = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
	localparam int TAYLOR_TERMS = 24;

	typedef logic [MAG_BITS-1:0] quarter_tbl_t [QUARTER_LEN+1];

	typedef struct packed {
		logic [BYTE_BITS-1:0]      amp;
		logic [SINE_ADDR_BITS-1:0] addr;
	} s1_t;

	typedef struct packed {
		logic [PROD_BITS-1:0] mag;
		logic                 neg;
	} s2_t;

	// Builds round(PEAK*sin(pi/2*j/QUARTER_LEN)) with a fixed-point Taylor series.
	// It runs only at elaboration.
	function automatic quarter_tbl_t build_quarter_wave();
		quarter_tbl_t tbl;
		logic [127:0] wide;
		logic [63:0]  x;
		logic [63:0]  x2;
		logic [63:0]  term;
		logic [63:0]  sum;
		for (int j = 0; j <= QUARTER_LEN; j++) begin
			wide = 128'(HALF_PI_Q62) * 128'(j);
			x    = wide[QUARTER_SHIFT +: 64];
			wide = 128'(x) * 128'(x);
			x2   = wide[62 +: 64];
			term = x;
			sum  = x;
			for (int n = 1; n <= TAYLOR_TERMS; n++) begin
				wide = 128'(term) * 128'(x2);
				term = wide[62 +: 64] / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			wide   = 128'(sum) * 128'(PEAK) + (128'd1 << 61);
			tbl[j] = wide[62 +: MAG_BITS];
		end
		return tbl;
	endfunction

	localparam quarter_tbl_t QUARTER_WAVE = build_quarter_wave();

endpackage

// ===== rtl/core/bmso_channels.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the amplitude bytes, the samples and the increment writes.
interface bmso_byte_if;
	logic                           valid;
	logic                           ready;
	logic [bmso_pkg::BYTE_BITS-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface bmso_sample_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [bmso_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface bmso_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bmso_pkg::INC_BITS-1:0] phase_increment;

	modport source (output valid, output phase_increment, input ready);
	modport sink (input valid, input phase_increment, output ready);
endinterface

// ===== rtl/core/byte_modulated_sine_oscillator.sv =====
`timescale 1ns / 1ps
// Byte-modulated sine oscillator: one signed sample of byte/255 * sin(phase) per amplitude byte.
//
// Channels: data carries one amplitude byte per request; samples returns one signed Q1.15
// sample per byte, in order; cfg writes the 32-bit phase increment (always ready).
// Each sample uses the phase held before its byte; the accumulator then advances by the
// increment and wraps. Change the increment only while no request is in flight.
// Throughput: one byte per cycle while samples are taken, held by a three-register pipeline
// (address, table and amplitude product, division by 255); every stage has its own valid bit.
// When the receiver stalls, the output register holds its sample and the earlier stages
// keep filling until they are full; data.ready falls only when all three hold results.
// Reset clears the phase to zero, restores the increment to 1118481067 (25 kHz at 96 kHz)
// and empties the pipeline. The sine table is constant logic, so no fill pass is needed.
module byte_modulated_sine_oscillator (
	input  logic          clk,
	input  logic          arst_n,
	bmso_cfg_if.sink      cfg,
	bmso_byte_if.sink     data,
	bmso_sample_if.source samples
);

	logic          valid_s1;
	logic          valid_s2;
	logic          valid_q;
	logic          rdy1;
	logic          rdy2;
	logic          rdy3;
	logic          take;
	bmso_pkg::s1_t data_s1;
	bmso_pkg::s2_t data_s2;

	assign rdy3 = !valid_q || samples.ready;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign data.ready = rdy1;
	assign take       = data.valid && rdy1;
	assign cfg.ready  = 1'b1;

	bmso_phase u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.inc_we   (cfg.valid),
		.inc_data (cfg.phase_increment),
		.en       (rdy1),
		.take     (take),
		.amp      (data.data_byte),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	bmso_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (rdy2),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	bmso_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (rdy3),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_q  (valid_q),
		.sample_q (samples.sample)
	);

	assign samples.valid = valid_q;

`ifndef SYNTHESIS
	// An empty output register means the whole pipeline can move.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> data.ready)
		else $error("data.ready low while the output register is empty");

	// An accepted request always lands in the first stage.
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted request did not reach the first stage");

	// The magnitude never exceeds the table peak, so the most negative code cannot appear.
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> samples.sample != {1'b1, {(bmso_pkg::SAMPLE_BITS-1){1'b0}}})
		else $error("sample reached the most negative code");
`endif

endmodule

// ===== rtl/core/bmso_phase.sv =====
`timescale 1ns / 1ps
// Phase accumulator, increment register and the first pipeline stage (amplitude and table address).
module bmso_phase (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                inc_we,
	input  logic [bmso_pkg::INC_BITS-1:0]       inc_data,
	input  logic                                en,
	input  logic                                take,
	input  logic [bmso_pkg::BYTE_BITS-1:0]      amp,
	output logic                                valid_s1,
	output bmso_pkg::s1_t                       data_s1
);

	logic [bmso_pkg::INC_BITS-1:0]   inc_q;
	logic [bmso_pkg::PHASE_BITS-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q <= bmso_pkg::INC_RESET;
		end else if (inc_we) begin
			inc_q <= inc_data;
		end
	end

	// The sample uses the phase held before this request; the step follows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				acc_q <= acc_q + bmso_pkg::PHASE_BITS'(inc_q);
			end
			if (en) begin
				valid_s1 <= take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1.amp  <= amp;
			data_s1.addr <= acc_q[bmso_pkg::PHASE_BITS-1 -: bmso_pkg::SINE_ADDR_BITS];
		end
	end

endmodule

// ===== rtl/core/bmso_scale.sv =====
`timescale 1ns / 1ps
// Second stage: quarter-wave table lookup with quadrant folding, times the amplitude byte.
module bmso_scale (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_s1,
	input  bmso_pkg::s1_t data_s1,
	output logic          valid_s2,
	output bmso_pkg::s2_t data_s2
);

	logic [1:0]                         quad;
	logic [bmso_pkg::QUARTER_SHIFT-1:0] pos;
	logic [bmso_pkg::IDX_BITS-1:0]      idx;
	logic [bmso_pkg::MAG_BITS-1:0]      sine_mag;
	logic [bmso_pkg::PROD_BITS-1:0]     prod;

	always_comb begin
		quad = data_s1.addr[bmso_pkg::SINE_ADDR_BITS-1 -: 2];
		pos  = data_s1.addr[bmso_pkg::QUARTER_SHIFT-1:0];
		// Odd quadrants run the quarter wave backward.
		if (quad[0]) begin
			idx = bmso_pkg::IDX_BITS'(bmso_pkg::QUARTER_LEN) - {1'b0, pos};
		end else begin
			idx = {1'b0, pos};
		end
		sine_mag = bmso_pkg::QUARTER_WAVE[idx];
		prod     = bmso_pkg::PROD_BITS'(sine_mag) * bmso_pkg::PROD_BITS'(data_s1.amp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			data_s2.mag <= prod;
			data_s2.neg <= quad[1];
		end
	end

endmodule

// ===== rtl/core/bmso_round.sv =====
`timescale 1ns / 1ps
// Output stage: rounded division by 255, sign restore and the output register.
module bmso_round (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    valid_s2,
	input  bmso_pkg::s2_t                           data_s2,
	output logic                                    valid_q,
	output logic signed [bmso_pkg::SAMPLE_BITS-1:0] sample_q
);

	logic [bmso_pkg::PROD_BITS-1:0]          biased;
	logic [bmso_pkg::WIDE_BITS-1:0]          wide;
	logic [bmso_pkg::MAG_BITS-1:0]           quot;
	logic signed [bmso_pkg::SAMPLE_BITS-1:0] signed_val;

	// Round to nearest with ties away from zero: (2m+255)/510 equals floor((m+127)/255).
	always_comb begin
		biased = data_s2.mag + bmso_pkg::ROUND_BIAS;
		wide   = bmso_pkg::WIDE_BITS'(biased) * bmso_pkg::WIDE_BITS'(bmso_pkg::RECIP);
		quot   = wide[bmso_pkg::DIV_SHIFT +: bmso_pkg::MAG_BITS];
		if (data_s2.neg) begin
			signed_val = -$signed({1'b0, quot});
		end else begin
			signed_val = $signed({1'b0, quot});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			sample_q <= signed_val;
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the byte-modulated sine oscillator, with its own sample predictor.
module tb;

	localparam int ADDR_LSB      = bmso_pkg::PHASE_BITS - bmso_pkg::SINE_ADDR_BITS;
	localparam int QTR_SHIFT     = bmso_pkg::SINE_ADDR_BITS - 2;
	localparam int QTR_LEN       = 1 << QTR_SHIFT;
	localparam int FULL_SCALE    = (1 << (bmso_pkg::SAMPLE_BITS - 1)) - 1;
	localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;
	localparam int SERIES_TERMS  = 24;

	logic clk;
	logic arst_n;

	bmso_cfg_if    cfg_ch ();
	bmso_byte_if   byte_ch ();
	bmso_sample_if samp_ch ();

	byte_modulated_sine_oscillator u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.data    (byte_ch),
		.samples (samp_ch)
	);

	// Predictor state: quarter-wave levels, phase accumulator and increment.
	int                                      quarter_sine [0:QTR_LEN];
	logic [bmso_pkg::PHASE_BITS-1:0]         phase_acc;
	logic [bmso_pkg::INC_BITS-1:0]           phase_step;
	logic signed [bmso_pkg::SAMPLE_BITS-1:0] pending_samples [$];

	int  mismatches     = 0;
	int  samples_checked = 0;
	int  bytes_sent     = 0;
	int  rates_used     = 0;
	bit  idle_on        = 1'b1;
	int  hold_left      = 0;
	int  stall_left     = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return p[125:62];
	endfunction

	// Quarter-wave level round(peak * sin(pi/2 * j / QTR_LEN)) from a Q2.62 Taylor series.
	function automatic int sine_level(input int j);
		logic [127:0] wide;
		logic [63:0]  x;
		logic [63:0]  x2;
		logic [63:0]  term;
		logic [63:0]  acc;
		wide = (128'(PI_HALF_Q62) * 128'(j)) >> QTR_SHIFT;
		x    = wide[63:0];
		x2   = q62_mul(x, x);
		term = x;
		acc  = x;
		for (int n = 1; n <= SERIES_TERMS; n++) begin
			term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		wide = 128'(acc) * 128'(FULL_SCALE) + (128'd1 << 61);
		return int'(wide[93:62]);
	endfunction

	function automatic logic signed [bmso_pkg::SAMPLE_BITS-1:0] modulated_sine(
		input logic [bmso_pkg::PHASE_BITS-1:0] phase,
		input logic [bmso_pkg::BYTE_BITS-1:0]  amp
	);
		logic [bmso_pkg::SINE_ADDR_BITS-1:0] addr;
		int offs;
		int level;
		int quot;
		addr  = phase[bmso_pkg::PHASE_BITS-1:ADDR_LSB];
		offs  = int'(addr[QTR_SHIFT-1:0]);
		level = addr[QTR_SHIFT] ? quarter_sine[QTR_LEN - offs] : quarter_sine[offs];
		// Round to nearest, ties away from zero, on the magnitude.
		quot  = (2 * level * int'(amp) + 255) / 510;
		return addr[QTR_SHIFT+1] ? bmso_pkg::SAMPLE_BITS'(-quot) :
			bmso_pkg::SAMPLE_BITS'(quot);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Sample receiver: random stall bursts, plus a long hold-off when one is requested.
	initial begin
		samp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				samp_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				samp_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				samp_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 8) - 1;
			end else begin
				samp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_samples
		logic signed [bmso_pkg::SAMPLE_BITS-1:0] want;
		if (arst_n && samp_ch.valid && samp_ch.ready) begin
			if (pending_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected sample %0d", samp_ch.sample));
			end else begin
				want = pending_samples.pop_front();
				samples_checked++;
				if (samp_ch.sample !== want) begin
					report_mismatch($sformatf("sample %0d: got %0d, want %0d",
						samples_checked, samp_ch.sample, want));
				end
			end
		end
	end

	task automatic send_byte(input logic [bmso_pkg::BYTE_BITS-1:0] amp);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= amp;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		// The sample uses the phase before this request; the step comes afterwards.
		pending_samples = {pending_samples, modulated_sine(phase_acc, amp)};
		phase_acc = phase_acc + bmso_pkg::PHASE_BITS'(phase_step);
		bytes_sent++;
	endtask

	task automatic stop_bytes();
		byte_ch.valid <= 1'b0;
	endtask

	task automatic wait_for_samples();
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_increment(input logic [bmso_pkg::INC_BITS-1:0] value);
		wait_for_samples();
		cfg_ch.valid           <= 1'b1;
		cfg_ch.phase_increment <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		phase_step = value;
		rates_used++;
	endtask

	function automatic logic [bmso_pkg::BYTE_BITS-1:0] random_amp();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return bmso_pkg::BYTE_BITS'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			send_byte(random_amp());
		end
		stop_bytes();
	endtask

	// Reset increment from phase zero: the first sample sits at sin(0).
	task automatic test_reset_state();
		logic [bmso_pkg::BYTE_BITS-1:0] amps [9];
		amps = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd127, 8'd255, 8'd254, 8'h55, 8'hAA};
		foreach (amps[i]) send_byte(amps[i]);
		stop_bytes();
	endtask

	// Quarter-turn steps move the phase through all four quadrants, at amplitudes 255 and 1.
	task automatic test_quadrants();
		set_increment(bmso_pkg::INC_BITS'(64'h4000_0000));
		for (int i = 0; i < 4; i++) send_byte(8'd255);
		for (int i = 0; i < 4; i++) send_byte(8'd1);
		stop_bytes();
	endtask

	task automatic test_extreme_rates();
		set_increment('1);
		for (int i = 0; i < 3; i++) send_byte(8'd255);
		stop_bytes();
		set_increment('0);
		for (int i = 0; i < 2; i++) send_byte(8'd255);
		stop_bytes();
	endtask

	// One table address per step walks every address of the sine table once.
	task automatic test_table_sweep();
		set_increment(bmso_pkg::INC_BITS'(64'd1 << ADDR_LSB));
		run_random(1 << bmso_pkg::SINE_ADDR_BITS);
	endtask

	task automatic test_random_rates();
		for (int r = 0; r < 4; r++) begin
			set_increment($urandom());
			run_random(100);
		end
		set_increment('0);
		run_random(50);
		set_increment('1);
		run_random(50);
		set_increment(bmso_pkg::INC_RESET);
		run_random(50);
	endtask

	// Long receiver hold-off while bytes keep coming, so the pipeline fills and stalls.
	task automatic test_output_backpressure();
		set_increment($urandom());
		hold_left = 80;
		for (int i = 0; i < 30; i++) send_byte(random_amp());
		stop_bytes();
	endtask

	task automatic test_streaming();
		set_increment($urandom());
		idle_on = 1'b0;
		run_random(60);
	endtask

	initial begin
		arst_n                 <= 1'b0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.phase_increment <= '0;
		byte_ch.valid          <= 1'b0;
		byte_ch.data_byte      <= '0;
		for (int j = 0; j <= QTR_LEN; j++) quarter_sine[j] = sine_level(j);
		phase_acc  = '0;
		phase_step = bmso_pkg::INC_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_quadrants();
		test_extreme_rates();
		test_table_sweep();
		test_random_rates();
		test_output_backpressure();
		test_streaming();

		wait_for_samples();
		repeat (4) @(posedge clk);
		$display("tb: %0d amplitude bytes sent, %0d samples checked, %0d mismatches",
			bytes_sent, samples_checked, mismatches);
		$display("tb: covered %0d phase increment settings, incl. zero, all-ones, reset",
			rates_used);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
